[src/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication, disabled in reset
`define ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

// next-cycle implication, always checked
`define ASSERT_NXT_ALWAYS(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("assertion failed");

`endif

[src/trd_pkg.sv]
// types, constants and area function for the triangle rasterizer
// no dependencies
package trd_pkg;

  localparam int TILE_BITS = 3;
  localparam int ADDR_W    = 16;
  localparam int AREA_W    = 21;
  localparam int DEN_W     = 20;
  localparam int NUM_W     = 28;
  localparam int DSH_W     = 27;
  localparam int IN_W      = 120;
  localparam int OUT_W     = 56;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SETUP, ST_AREA_A, ST_AREA_B, ST_AREA_C,
    ST_MUL_A, ST_MUL_B, ST_MUL_C, ST_DIV, ST_TEST, ST_FLUSH
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  // doubled signed area of triangle u, v, w
  function automatic logic signed [AREA_W-1:0] doubled_area(
    input logic [7:0] ux, input logic [7:0] uy,
    input logic [7:0] vx, input logic [7:0] vy,
    input logic [7:0] wx, input logic [7:0] wy);
    logic signed [9:0]  d1, d2, d3, s1, s2, s3;
    logic signed [19:0] p1, p2, p3;
    d1 = $signed({2'b0, vy}) - $signed({2'b0, uy});
    d2 = $signed({2'b0, wy}) - $signed({2'b0, vy});
    d3 = $signed({2'b0, uy}) - $signed({2'b0, wy});
    s1 = $signed({2'b0, vx}) + $signed({2'b0, ux});
    s2 = $signed({2'b0, wx}) + $signed({2'b0, vx});
    s3 = $signed({2'b0, ux}) + $signed({2'b0, wx});
    p1 = d1 * s1;
    p2 = d2 * s2;
    p3 = d3 * s3;
    return AREA_W'(p1) + AREA_W'(p2) + AREA_W'(p3);
  endfunction

endpackage

[src/trd_depth_mem.sv]
// depth store: one 8-bit depth per screen pixel, registered read
// depends on trd_pkg
module trd_depth_mem (
  input  logic            clk,
  input  trd_pkg::mem_req_t req,
  output logic [7:0]      rd_data
);
  import trd_pkg::*;

  logic [7:0] mem [0:(1<<ADDR_W)-1];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

endmodule

[src/triangle_rasterizer_depth_test.sv]
// Tiled triangle rasterizer with depth test. After reset the depth store is
// cleared and no transaction is taken. Each triangle then goes through
// setup; each bounding-box pixel of the tile that lies outside the triangle
// goes through the area terms, and each pixel inside it through the area
// terms, three depth products, an 8-step restoring divider and the depth
// test, plus a flush state at the end when any pixel is visited; a passing
// pixel also waits while the previous pixel write is held by m_tready. A
// degenerate triangle or an empty box ends after setup. The depth store
// read-modify-write follows that per-pixel sequence.
// depends on trd_pkg, trd_depth_mem
module triangle_rasterizer_depth_test (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // a_x, a_y, a_depth, b_x, b_y, b_depth, c_x, c_y, c_depth, fill_color,
  // tile_col, tile_row, zero pad
  input  logic [trd_pkg::IN_W-1:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pixel_x, pixel_y, pixel_depth, write_color
  output logic [trd_pkg::OUT_W-1:0] m_tdata,
  output logic        m_tlast
);
  import trd_pkg::*;

  state_t state, state_next;

  logic [7:0]  ax, ay, az, bx, by, bz, cx, cy, cz;
  logic [31:0] color;
  logic [4:0]  tcol, trow;
  logic        neg;
  logic [DEN_W-1:0] den;
  logic [7:0]  x, y, y0, x1, y1;
  logic signed [AREA_W-1:0] ea, eb, ec;
  logic [NUM_W-1:0] num;
  logic [DSH_W-1:0] dsh;
  logic [2:0]  cnt;
  logic [7:0]  quot;
  logic        pend_valid;
  logic [7:0]  pend_x, pend_y, pend_z;
  logic [15:0] clr_addr;
  mem_req_t    req;
  logic [7:0]  stored;

  logic signed [AREA_W-1:0] s_area, area_a, area_b, area_c;
  logic signed [AREA_W-1:0] norm_a, norm_b, norm_c;
  logic [7:0]  mn_x, mx_x, mn_y, mx_y, tx0, ty0, bx0, bx1, by0, by1;
  logic        out_free, pass, stall, last_pix, push, push_last, ge;

  trd_depth_mem u_mem (.clk(clk), .req(req), .rd_data(stored));

  always_comb begin
    s_area = doubled_area(ax, ay, bx, by, cx, cy);
    area_a = doubled_area(x, y, bx, by, cx, cy);
    area_b = doubled_area(x, y, cx, cy, ax, ay);
    area_c = doubled_area(x, y, ax, ay, bx, by);
    norm_a = neg ? -area_a : area_a;
    norm_b = neg ? -area_b : area_b;
    norm_c = neg ? -area_c : area_c;
    mn_x = (ax < bx) ? ((ax < cx) ? ax : cx) : ((bx < cx) ? bx : cx);
    mx_x = (ax > bx) ? ((ax > cx) ? ax : cx) : ((bx > cx) ? bx : cx);
    mn_y = (ay < by) ? ((ay < cy) ? ay : cy) : ((by < cy) ? by : cy);
    mx_y = (ay > by) ? ((ay > cy) ? ay : cy) : ((by > cy) ? by : cy);
    tx0 = {tcol, TILE_BITS'(0)};
    ty0 = {trow, TILE_BITS'(0)};
    bx0 = (mn_x > tx0) ? mn_x : tx0;
    bx1 = (mx_x < (tx0 | 8'd7)) ? mx_x : (tx0 | 8'd7);
    by0 = (mn_y > ty0) ? mn_y : ty0;
    by1 = (mx_y < (ty0 | 8'd7)) ? mx_y : (ty0 | 8'd7);
    ge = num >= NUM_W'(dsh);
  end

  always_comb begin
    out_free  = !m_tvalid || m_tready;
    pass      = quot >= stored;
    last_pix  = (x == x1) && (y == y1);
    stall     = 1'b0;
    push      = 1'b0;
    push_last = 1'b0;
    s_tready  = state == ST_IDLE;
    state_next = state;
    req.wr_en   = 1'b0;
    req.wr_addr = {y, x};
    req.wr_data = quot;
    req.rd_addr = {y, x};
    unique case (state)
      ST_CLEAR: begin
        req.wr_en   = 1'b1;
        req.wr_addr = clr_addr;
        req.wr_data = 8'd0;
        if (clr_addr == 16'hFFFF) state_next = ST_IDLE;
      end
      ST_IDLE:   if (s_tvalid) state_next = ST_SETUP;
      ST_SETUP: begin
        if (s_area == '0 || bx0 > bx1 || by0 > by1) state_next = ST_IDLE;
        else state_next = ST_AREA_A;
      end
      ST_AREA_A: state_next = ST_AREA_B;
      ST_AREA_B: state_next = ST_AREA_C;
      ST_AREA_C: begin
        if (ea[AREA_W-1] || eb[AREA_W-1] || norm_c[AREA_W-1])
          state_next = last_pix ? ST_FLUSH : ST_AREA_A;
        else state_next = ST_MUL_A;
      end
      ST_MUL_A:  state_next = ST_MUL_B;
      ST_MUL_B:  state_next = ST_MUL_C;
      ST_MUL_C:  state_next = ST_DIV;
      ST_DIV:    if (cnt == 3'd0) state_next = ST_TEST;
      ST_TEST: begin
        stall = pass && pend_valid && !out_free;
        push  = pass && pend_valid && out_free;
        req.wr_en = pass && !stall;
        if (!stall) state_next = last_pix ? ST_FLUSH : ST_AREA_A;
      end
      ST_FLUSH: begin
        push      = pend_valid && out_free;
        push_last = 1'b1;
        if (!pend_valid || out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (state == ST_CLEAR) clr_addr <= clr_addr + 16'd1;
      if (push) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {color, pend_z, pend_y, pend_x};
        m_tlast  <= push_last;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == ST_TEST && pass && !stall) begin
        pend_valid <= 1'b1;
        pend_x <= x;
        pend_y <= y;
        pend_z <= quot;
      end else if (push) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          ax <= s_tdata[7:0];    ay <= s_tdata[15:8];   az <= s_tdata[23:16];
          bx <= s_tdata[31:24];  by <= s_tdata[39:32];  bz <= s_tdata[47:40];
          cx <= s_tdata[55:48];  cy <= s_tdata[63:56];  cz <= s_tdata[71:64];
          color <= s_tdata[103:72];
          tcol  <= s_tdata[108:104];
          trow  <= s_tdata[113:109];
        end
      end
      ST_SETUP: begin
        neg <= s_area[AREA_W-1];
        den <= s_area[AREA_W-1] ? DEN_W'(-s_area) : DEN_W'(s_area);
        x  <= bx0;
        y  <= by0;
        y0 <= by0;
        x1 <= bx1;
        y1 <= by1;
      end
      ST_AREA_A: ea <= norm_a;
      ST_AREA_B: eb <= norm_b;
      ST_AREA_C: begin
        ec <= norm_c;
        if (state_next != ST_MUL_A) begin
          if (y == y1) begin
            x <= x + 8'd1;
            y <= y0;
          end else begin
            y <= y + 8'd1;
          end
        end
      end
      ST_MUL_A: num <= NUM_W'(ea[DEN_W-1:0]) * NUM_W'(az);
      ST_MUL_B: num <= num + NUM_W'(eb[DEN_W-1:0]) * NUM_W'(bz);
      ST_MUL_C: begin
        num  <= num + NUM_W'(ec[DEN_W-1:0]) * NUM_W'(cz);
        dsh  <= {den, 7'd0};
        cnt  <= 3'd7;
        quot <= 8'd0;
      end
      ST_DIV: begin
        if (ge) num <= num - NUM_W'(dsh);
        quot <= {quot[6:0], ge};
        dsh  <= dsh >> 1;
        cnt  <= cnt - 3'd1;
      end
      ST_TEST: begin
        if (!stall && !last_pix) begin
          if (y == y1) begin
            x <= x + 8'd1;
            y <= y0;
          end else begin
            y <= y + 8'd1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

[src/trd_checker.sv]
// port-level checks for the triangle rasterizer, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module trd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tlast
);
  `ASSERT_NXT(hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `ASSERT_NXT(hold_data, clk, rst, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
  `ASSERT_NXT(busy_after_take, clk, rst, s_tvalid && s_tready, !s_tready)
  `ASSERT_NXT_ALWAYS(quiet_after_rst, clk, rst, !m_tvalid && !s_tready)
endmodule

bind triangle_rasterizer_depth_test trd_checker u_trd_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
